// ----- rtl/lws_pkg.sv -----
// Shared constants and types for the latency window monitor.
package lws_pkg;
  localparam int NumTimers   = 16;
  localparam int WindowDepth = 64;
  localparam int StampBits   = 48;
  localparam int TidW  = (NumTimers > 1) ? $clog2(NumTimers) : 1;
  localparam int RidW  = $clog2(WindowDepth);
  localparam int CntW  = $clog2(WindowDepth + 1);
  localparam int SumW  = 32 + CntW;
  localparam int RingW = StampBits + 32;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_STOP   = 2'd1,
    REQ_ADD    = 2'd2,
    REQ_UPDATE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RUNNING  = 2'd1,
    ST_NOTSTART = 2'd2,
    ST_OVER     = 2'd3
  } status_t;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_WINDOW    = 1'b1;
endpackage

// ----- rtl/lws_ram.sv -----
// Generic single-port-write, single-read synchronous RAM with registered read.
module lws_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ----- rtl/lws_div.sv -----
// Restoring divider: sum by sample count, one quotient bit per cycle.
module lws_div
  import lws_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SumW-1:0]   dividend,
  input  logic [CntW-1:0]   divisor,
  output logic              done,
  output logic [31:0]       quotient
);
  logic [SumW-1:0] q_r;
  logic [CntW:0]   rem_r;
  logic [CntW-1:0] den_r;
  logic [$clog2(SumW+1)-1:0] step_r;
  logic            busy_r;
  logic [CntW:0]   trial;

  assign trial    = {rem_r[CntW-1:0], q_r[SumW-1]};
  assign quotient = q_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      step_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= ($clog2(SumW+1))'(SumW);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == ($clog2(SumW+1))'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_r <= trial - {1'b0, den_r};
        q_r   <= {q_r[SumW-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[SumW-2:0], 1'b0};
      end
    end
  end
endmodule

// ----- rtl/latency_window_stats.sv -----
// Latency window monitor top level: timers, sample ring, window update sequencer.
// One beat in, one beat out, one request in flight: the input stalls while a request is
// processed and while its result beat waits. Start, stop and add pass through the timer
// and ring read, execute with write-back, and output states before their result is valid,
// and no new request is taken until that result beat has left. An update reads the ring
// once per cycle: it walks the expired entries from the oldest, then the held ones, then
// runs the count divider (start, 39 quotient bits, done); at a full ring of 64 the walk is
// bounded by the single ring read port.
module latency_window_stats
  import lws_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_request_id,
  input  logic [31:0] in_time_us,
  input  logic [47:0] in_now_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_stats_valid,
  output logic [31:0] out_mean_us,
  output logic [31:0] out_min_us,
  output logic [31:0] out_max_us,
  output logic [6:0]  out_window_count,
  output logic [31:0] out_over_count,
  output logic [31:0] out_measured_us
);
  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_DROP, S_SCAN, S_DIV, S_OUT
  } state_t;

  state_t state_r;
  logic [22:0] thr_r;
  logic [31:0] win_r;
  logic [1:0]  req_r;
  logic [3:0]  id_r;
  logic [31:0] tus_r;
  logic [StampBits-1:0] now_r;
  logic [NumTimers-1:0] run_r;
  logic [RidW-1:0] head_r;
  logic [CntW-1:0] count_r, scan_r;
  logic [31:0] over_r;
  logic stok_r;
  logic [31:0] mean_r, min_r, max_r;
  logic [SumW-1:0] sum_r;
  logic [StampBits:0] cut_r;
  logic cut_en_r;
  logic [RidW-1:0] rd_idx_r;
  logic div_go_r;

  // timer store
  logic tmr_we;
  logic [StampBits-1:0] tmr_q;
  // ring store
  logic ring_we;
  logic [RingW-1:0] ring_q;
  logic [RidW-1:0]  rd_addr;

  logic id_ok;
  assign id_ok = ({28'd0, id_r} < 32'(NumTimers));

  logic [StampBits-1:0] dur;
  logic [31:0] samp;
  logic [41:0] thr_us;
  logic over;
  assign dur    = now_r - tmr_q;
  assign samp   = (req_r == REQ_STOP) ? dur[31:0] : tus_r;
  assign thr_us = 42'(thr_r) * 42'd1000;
  assign over   = (thr_r != '0) && ({10'd0, samp} > thr_us);

  logic is_stop_ok;
  assign is_stop_ok = id_ok && run_r[id_r[TidW-1:0]];

  assign tmr_we  = (state_r == S_EXEC) && (req_r == REQ_START) && id_ok
                   && !run_r[id_r[TidW-1:0]];
  assign ring_we = (state_r == S_EXEC) && !over &&
                   ((req_r == REQ_ADD) || ((req_r == REQ_STOP) && is_stop_ok));

  lws_ram #(.Width(StampBits), .Depth(NumTimers)) u_tmr (
    .clk(clk), .wr_en(tmr_we), .wr_addr(id_r[TidW-1:0]), .wr_data(now_r),
    .rd_addr(id_r[TidW-1:0]), .rd_data(tmr_q));

  lws_ram #(.Width(RingW), .Depth(WindowDepth)) u_ring (
    .clk(clk), .wr_en(ring_we), .wr_addr(head_r), .wr_data({now_r, samp}),
    .rd_addr(rd_addr), .rd_data(ring_q));

  // oldest entry index = head - count (mod depth)
  logic [RidW-1:0] oldest;
  logic [CntW+RidW:0] old_full;
  assign old_full = (CntW+RidW+1)'(head_r) + (CntW+RidW+1)'(WindowDepth)
                    - (CntW+RidW+1)'(count_r);
  assign oldest = RidW'(old_full % WindowDepth);
  assign rd_addr = (state_r == S_IDLE || state_r == S_READ) ? oldest : rd_idx_r;

  logic [41:0] span;
  assign span = 42'(win_r) * 42'd1000;

  logic div_done;
  logic [31:0] div_q;
  lws_div u_div (.clk(clk), .rst_n(rst_n), .start(div_go_r), .dividend(sum_r),
    .divisor(count_r), .done(div_done), .quotient(div_q));

  // hold off the next request until the result beat has left
  assign in_stall = (state_r != S_IDLE) || out_valid;
  logic [CntW-1:0] cnt_inc;
  assign cnt_inc = (count_r == CntW'(WindowDepth)) ? count_r : count_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; thr_r <= '0; win_r <= 32'd1000; run_r <= '0;
      head_r <= '0; count_r <= '0; over_r <= '0; stok_r <= 1'b0;
      mean_r <= '0; min_r <= '0; max_r <= '0; out_valid <= 1'b0;
      div_go_r <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_THRESHOLD) thr_r <= cfg_data[22:0];
        else win_r <= cfg_data;
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid && !out_valid) begin
          req_r <= in_req_type; id_r <= in_request_id; tus_r <= in_time_us;
          now_r <= in_now_us[StampBits-1:0];
          state_r <= S_READ;
        end
        S_READ: begin
          if (req_r == REQ_UPDATE) begin
            cut_r    <= {1'b0, now_r} - (StampBits+1)'(span);
            cut_en_r <= {6'd0, now_r} >= span;
            rd_idx_r <= oldest + 1'b1;
            state_r  <= S_DROP;
          end else state_r <= S_EXEC;
          out_measured_us <= '0;
          out_status      <= ST_OK;
        end
        S_EXEC: begin
          case (req_r)
            REQ_START: if (id_ok) begin
              if (run_r[id_r[TidW-1:0]]) out_status <= ST_RUNNING;
              run_r[id_r[TidW-1:0]] <= 1'b1;
            end
            REQ_STOP: if (!is_stop_ok) out_status <= ST_NOTSTART;
              else begin
                out_measured_us <= samp;
                run_r[id_r[TidW-1:0]] <= 1'b0;
              end
            default: out_measured_us <= samp;
          endcase
          if ((req_r == REQ_ADD) || ((req_r == REQ_STOP) && is_stop_ok)) begin
            if (over) begin
              out_status <= ST_OVER;
              over_r <= over_r + 1'b1;
            end else begin
              head_r  <= head_r + 1'b1;
              count_r <= cnt_inc;
            end
          end
          state_r <= S_OUT;
        end
        S_DROP: begin
          // ring_q holds the oldest remaining entry
          if (count_r != '0 && cut_en_r &&
              {1'b0, ring_q[RingW-1:32]} <= cut_r) begin
            count_r  <= count_r - 1'b1;
            rd_idx_r <= rd_idx_r + 1'b1;
          end else begin
            // the oldest held entry is folded in here; the read of the next one is in flight
            scan_r   <= (count_r == '0) ? '0 : count_r - 1'b1;
            sum_r    <= SumW'(ring_q[31:0]);
            min_r    <= ring_q[31:0];
            max_r    <= ring_q[31:0];
            rd_idx_r <= rd_idx_r + 1'b1;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          // ring_q shows the second held entry on entry to this state
          if (scan_r == '0) begin
            if (count_r == '0) begin
              stok_r <= 1'b0; mean_r <= '0; min_r <= '0; max_r <= '0;
              state_r <= S_OUT;
            end else begin
              div_go_r <= 1'b1;
              state_r  <= S_DIV;
            end
          end else begin
            sum_r <= sum_r + SumW'(ring_q[31:0]);
            if (ring_q[31:0] < min_r) min_r <= ring_q[31:0];
            if (ring_q[31:0] > max_r) max_r <= ring_q[31:0];
            scan_r   <= scan_r - 1'b1;
            rd_idx_r <= rd_idx_r + 1'b1;
          end
        end
        S_DIV: if (div_done) begin
          stok_r <= 1'b1; mean_r <= div_q; state_r <= S_OUT;
        end
        S_OUT: if (!out_valid) begin
          out_valid <= 1'b1;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_stats_valid  = stok_r;
  assign out_mean_us      = mean_r;
  assign out_min_us       = min_r;
  assign out_max_us       = max_r;
  assign out_window_count = 7'(count_r);
  assign out_over_count   = over_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(WindowDepth)) else $error("ring count overflow");
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_ring_we_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ring_we |-> (state_r == S_EXEC)) else $error("stray ring write");
endmodule

// ----- bench/latency_window_stats_tb.sv -----
// Self-checking testbench for the latency window monitor, with its own predictor.
module latency_window_stats_tb
  import lws_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 4000;
  localparam int DrainCycles = 250;

  typedef struct packed {
    status_t     status;
    logic        stats_valid;
    logic [31:0] mean_us;
    logic [31:0] min_us;
    logic [31:0] max_us;
    logic [6:0]  window_count;
    logic [31:0] over_count;
    logic [31:0] measured_us;
  } lat_result_t;

  typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    req_t        req;
    logic [3:0]  id;
    logic [31:0] tus;
    logic [47:0] now;
    logic        has_status;
    status_t     status;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_THRESHOLD;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = REQ_START;
  logic [3:0]  in_request_id = '0;
  logic [31:0] in_time_us = '0;
  logic [47:0] in_now_us = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic        out_stats_valid;
  logic [31:0] out_mean_us, out_min_us, out_max_us, out_over_count, out_measured_us;
  logic [6:0]  out_window_count;

  latency_window_stats u_top (.*);

  always #4 clk = ~clk;

  // predictor state
  longint unsigned thr_ms, win_ms;
  logic [47:0] tmr_start [NumTimers];
  logic        tmr_run [NumTimers];
  logic [47:0] smp_stamp [WindowDepth];
  logic [31:0] smp_val [WindowDepth];
  int unsigned ring_head, ring_fill;
  logic [31:0] reject_total;
  logic        st_ok;
  logic [31:0] st_mean, st_min, st_max;

  lat_result_t pending_stats[$];
  int  mismatches = 0;
  bit  quiet = 1'b0;
  int  stall_left = 0;
  int  idle_cycles = 0;

  function automatic bit store_sample(logic [31:0] v, logic [47:0] now);
    if (thr_ms != 0 && longint'(v) > thr_ms * 1000) begin
      reject_total++;
      return 1'b0;
    end
    smp_stamp[ring_head] = now;
    smp_val[ring_head] = v;
    ring_head = (ring_head + 1) % WindowDepth;
    if (ring_fill < WindowDepth) ring_fill++;
    return 1'b1;
  endfunction

  function automatic void refresh_window(logic [47:0] now);
    longint unsigned span, cutoff, total;
    int unsigned idx;
    logic [31:0] lo, hi;
    span = win_ms * 1000;
    total = 0;
    lo = '1;
    hi = '0;
    if (longint'(now) >= span) begin
      cutoff = longint'(now) - span;
      while (ring_fill > 0) begin
        idx = (ring_head + WindowDepth - ring_fill) % WindowDepth;
        if (longint'(smp_stamp[idx]) > cutoff) break;
        ring_fill--;
      end
    end
    if (ring_fill == 0) begin
      st_ok = 1'b0; st_mean = '0; st_min = '0; st_max = '0;
      return;
    end
    for (int i = 0; i < ring_fill; i++) begin
      idx = (ring_head + WindowDepth - ring_fill + i) % WindowDepth;
      if (smp_val[idx] < lo) lo = smp_val[idx];
      if (smp_val[idx] > hi) hi = smp_val[idx];
      total += smp_val[idx];
    end
    st_ok = 1'b1;
    st_mean = 32'(total / ring_fill);
    st_min = lo;
    st_max = hi;
  endfunction

  function automatic lat_result_t predict_latency(req_t req, logic [3:0] id,
                                                  logic [31:0] tus, logic [47:0] now);
    lat_result_t r;
    logic [47:0] dur;
    r = '0;
    r.status = ST_OK;
    case (req)
      REQ_START: begin
        if (tmr_run[id]) r.status = ST_RUNNING;
        else tmr_start[id] = now;
        tmr_run[id] = 1'b1;
      end
      REQ_STOP: begin
        if (!tmr_run[id]) begin
          r.status = ST_NOTSTART;
        end else begin
          dur = now - tmr_start[id];
          r.measured_us = dur[31:0];
          if (!store_sample(r.measured_us, now)) r.status = ST_OVER;
          tmr_run[id] = 1'b0;
        end
      end
      REQ_ADD: begin
        r.measured_us = tus;
        if (!store_sample(tus, now)) r.status = ST_OVER;
      end
      default: refresh_window(now);
    endcase
    r.stats_valid = st_ok;
    r.mean_us = st_mean;
    r.min_us = st_min;
    r.max_us = st_max;
    r.window_count = 7'(ring_fill);
    r.over_count = reject_total;
    return r;
  endfunction

  task automatic issue_request(req_t req, logic [3:0] id, logic [31:0] tus,
                               logic [47:0] now, logic has_st, status_t st);
    lat_result_t r;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_request_id <= id;
    in_time_us <= tus;
    in_now_us <= now;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    r = predict_latency(req, id, tus, now);
    if (has_st) r.status = st;
    pending_stats.push_back(r);
  endtask

  task automatic drain_to_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    drain_to_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_THRESHOLD) thr_ms = val & 32'h7F_FFFF;
    else win_ms = val;
  endtask

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    lat_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {status_t'(out_status), out_stats_valid, out_mean_us, out_min_us, out_max_us,
             out_window_count, out_over_count, out_measured_us};
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
      end else begin
        want = pending_stats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // watchdog on beats in either direction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("latency_window_stats test failed");
      $finish;
    end
  end

  stim_row_t dir_rows[$];
  logic [31:0] thr_set[6] = '{32'd0, 32'hFF80_0000 | 32'd4194303, 32'd1, 32'd20, 32'd0, 32'd3};
  logic [31:0] win_set[6] = '{32'd1000, 32'hFFFF_FFFF, 32'd0, 32'd2, 32'd5, 32'd50};

  function automatic stim_row_t req_row(req_t req, logic [3:0] id, logic [31:0] tus,
                                        logic [47:0] now, logic has_st, status_t st);
    stim_row_t s;
    s.kind = ROW_REQ; s.req = req; s.id = id; s.tus = tus; s.now = now;
    s.has_status = has_st; s.status = st;
    return s;
  endfunction

  function automatic stim_row_t cfg_row(logic [0:0] idx, logic [31:0] val);
    stim_row_t s;
    s = req_row(REQ_START, '0, val, '0, 1'b0, ST_OK);
    s.kind = ROW_CFG;
    s.id = {3'b0, idx};
    return s;
  endfunction

  initial begin
    logic [47:0] now;
    logic [3:0] id;
    logic [31:0] tus;
    longint unsigned step_max;
    int pick;
    req_t req;

    thr_ms = 0; win_ms = 1000;
    ring_head = 0; ring_fill = 0; reject_total = '0;
    st_ok = 1'b0; st_mean = '0; st_min = '0; st_max = '0;
    foreach (tmr_run[i]) begin tmr_run[i] = 1'b0; tmr_start[i] = '0; end
    foreach (smp_val[i]) begin smp_val[i] = '0; smp_stamp[i] = '0; end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    dir_rows = '{
      req_row(REQ_UPDATE, 4'd0, 32'd0, 48'd0, 1'b1, ST_OK),
      req_row(REQ_STOP, 4'd3, 32'd0, 48'd50, 1'b1, ST_NOTSTART),
      req_row(REQ_START, 4'd0, 32'd0, 48'd100, 1'b1, ST_OK),
      req_row(REQ_START, 4'd0, 32'd0, 48'd200, 1'b1, ST_RUNNING),
      req_row(REQ_STOP, 4'd0, 32'd0, 48'd1100, 1'b1, ST_OK),
      req_row(REQ_ADD, 4'd7, 32'hFFFF_FFFF, 48'd1200, 1'b1, ST_OK),
      req_row(REQ_ADD, 4'd8, 32'd0, 48'd1300, 1'b1, ST_OK),
      req_row(REQ_UPDATE, 4'd0, 32'd0, 48'd2000, 1'b0, ST_OK),
      // stop stamp wraps past the top of the timestamp range
      req_row(REQ_START, 4'd15, 32'd0, 48'hFFFF_FFFF_FFF6, 1'b1, ST_OK),
      req_row(REQ_STOP, 4'd15, 32'd0, 48'd5, 1'b1, ST_OK),
      req_row(REQ_UPDATE, 4'd0, 32'd0, 48'hFFFF_FFFF_FFFF, 1'b0, ST_OK),
      req_row(REQ_ADD, 4'd0, 32'd1, 48'hFFFF_FFFF_FFFF, 1'b1, ST_OK),
      cfg_row(CFG_THRESHOLD, 32'd1),
      req_row(REQ_ADD, 4'd0, 32'd1001, 48'd10, 1'b1, ST_OVER),
      req_row(REQ_ADD, 4'd0, 32'd1000, 48'd11, 1'b1, ST_OK),
      req_row(REQ_START, 4'd2, 32'd0, 48'd20, 1'b1, ST_OK),
      req_row(REQ_STOP, 4'd2, 32'd0, 48'd5000, 1'b1, ST_OVER),
      req_row(REQ_STOP, 4'd2, 32'd0, 48'd5001, 1'b1, ST_NOTSTART),
      // zero window with out-of-order stamps: oldest entry is newer than cutoff
      cfg_row(CFG_WINDOW, 32'd0),
      req_row(REQ_UPDATE, 4'd0, 32'd0, 48'd11, 1'b0, ST_OK),
      cfg_row(CFG_WINDOW, 32'hFFFF_FFFF),
      req_row(REQ_UPDATE, 4'd0, 32'd0, 48'd12, 1'b0, ST_OK),
      cfg_row(CFG_THRESHOLD, 32'd0)
    };
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_reg(dir_rows[i].id[0], dir_rows[i].tus);
      else issue_request(dir_rows[i].req, dir_rows[i].id, dir_rows[i].tus,
                         dir_rows[i].now, dir_rows[i].has_status, dir_rows[i].status);
    end

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_THRESHOLD, thr_set[ph]);
      write_reg(CFG_WINDOW, win_set[ph]);
      quiet = (ph == 5);
      now = {16'(ph == 1 ? $urandom : 0), 32'($urandom_range(0, 1 << 30))};
      step_max = (win_ms * 1000) / 16 + 40;
      if (step_max > 200000) step_max = 200000;
      for (int n = 0; n < 290; n++) begin
        now = now + 48'($urandom_range(0, int'(step_max)));
        pick = $urandom_range(0, 99);
        id = 4'($urandom);
        tus = 0;
        if (pick < 25) begin
          req = REQ_START;
        end else if (pick < 50) begin
          req = REQ_STOP;
          if ($urandom_range(0, 9) < 8)
            for (int k = 0; k < NumTimers; k++) if (tmr_run[(id + k) % NumTimers]) begin
              id = 4'((id + k) % NumTimers);
              break;
            end
        end else if (pick < 80) begin
          req = REQ_ADD;
          if ($urandom_range(0, 3) == 0) tus = $urandom;
          else if (thr_ms != 0) tus = $urandom_range(0, int'(thr_ms * 2000 + 2));
          else tus = $urandom_range(0, 100000);
        end else begin
          req = REQ_UPDATE;
        end
        if (req != REQ_ADD && $urandom_range(0, 7) == 0) tus = $urandom;
        issue_request(req, id, tus, now, 1'b0, ST_OK);
      end
    end

    drain_to_idle();
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("latency_window_stats test passed");
    end else begin
      $display("latency_window_stats test failed");
    end
    $finish;
  end

endmodule
